### sv/bale_pkg.sv
// shared types and constants for the byte array list engine
package bale_pkg;

    localparam int POS_W  = 9;
    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        REQ_APPEND    = 3'd0,
        REQ_INSERT    = 3'd1,
        REQ_DELETE    = 3'd2,
        REQ_DEL_RANGE = 3'd3,
        REQ_CLEAR     = 3'd4,
        REQ_READ      = 3'd5,
        REQ_FIND      = 3'd6,
        REQ_REVERSE   = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL,
        ST_ROT,
        ST_POP,
        ST_COPY,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_ZERO,
        CELL_ROTATE,
        CELL_POP,
        CELL_COPY
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  last;
        logic [POS_W-1:0]  count;
        logic [BYTE_W-1:0] value;
    } bale_ctrl_t;

endpackage

### sv/bale_cell.sv
// one list slot with its neighbor links and a reversal stack slot
module bale_cell
    import bale_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int INDEX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bale_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] lower_main,
    input  logic [BYTE_W-1:0] upper_main,
    input  logic [BYTE_W-1:0] lower_aux,
    input  logic [BYTE_W-1:0] head_main,
    output logic [BYTE_W-1:0] main_q,
    output logic [BYTE_W-1:0] aux_q
);

    localparam int AW    = $clog2(DEPTH) + 1;
    localparam int CMP_W = (AW > POS_W) ? AW : POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [BYTE_W-1:0] main_reg, main_next;
    logic [BYTE_W-1:0] aux_reg, aux_next;
    logic [CMP_W-1:0]  pos_c, last_c, count_c;

    assign pos_c   = CMP_W'(ctrl.pos);
    assign last_c  = CMP_W'(ctrl.last);
    assign count_c = CMP_W'(ctrl.count);

    always_comb begin
        main_next = main_reg;
        aux_next  = aux_reg;
        case (ctrl.op)
            CELL_LOAD: begin
                if (MY_IDX == pos_c) main_next = ctrl.value;
            end
            CELL_SHIFT_UP: begin
                if (MY_IDX > pos_c) main_next = lower_main;
                else if (MY_IDX == pos_c) main_next = ctrl.value;
            end
            CELL_SHIFT_DOWN: begin
                if (MY_IDX >= pos_c) main_next = upper_main;
            end
            CELL_ZERO: begin
                main_next = '0;
            end
            CELL_ROTATE: begin
                if (MY_IDX < last_c) main_next = upper_main;
                else if (MY_IDX == last_c) main_next = head_main;
            end
            CELL_POP: begin
                main_next = upper_main;
                aux_next  = lower_aux;
            end
            CELL_COPY: begin
                main_next = (MY_IDX < count_c) ? aux_reg : '0;
            end
            default: begin
                main_next = main_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_reg <= '0;
        end else begin
            main_reg <= main_next;
        end
    end

    always_ff @(posedge aclk) begin
        aux_reg <= aux_next;
    end

    assign main_q = main_reg;
    assign aux_q  = aux_reg;

endmodule

### sv/byte_array_list_engine.sv
// top level: request decoder, sequencer and row of list cells
// steps: append, insert, delete, clear go straight to the result; delete range shifts
//   once per removed entry; read and find rotate through all entries; reverse pops all
//   entries, then copies back; one request at a time, the cell row moving one slot
//   per cycle during rotate, range shift and reversal
// reset: all slots zero, count zero, capacity 256, no result pending
module byte_array_list_engine
    import bale_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // position, end_position, value, zero pad
    input  logic [2:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // success, read_byte, match_found, match_index,
                                   // item_count, list_empty, list_full, zero pad
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    localparam int AW    = $clog2(DEPTH) + 1;
    localparam int CMP_W = (AW > POS_W) ? AW : POS_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [POS_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  cap_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]  steps_reg, steps_next;
    logic              ok_reg, ok_next;
    logic [BYTE_W-1:0] rd_reg, rd_next;
    logic              found_reg, found_next;
    logic [BYTE_W-1:0] idx_reg, idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    bale_ctrl_t        ctrl;
    logic [BYTE_W-1:0] main_w [DEPTH];
    logic [BYTE_W-1:0] aux_w  [DEPTH];
    logic [BYTE_W-1:0] head;

    req_t              in_req;
    logic [POS_W-1:0]  in_pos, in_end, clamp_end;
    logic [BYTE_W-1:0] in_val;
    logic              full_now, full_after, out_free, last_step;

    assign in_req = req_t'(s_tuser);
    assign in_pos = s_tdata[8:0];
    assign in_end = s_tdata[17:9];
    assign in_val = s_tdata[25:18];
    assign head   = main_w[0];

    assign full_now   = (count_reg >= cap_reg) || (CMP_W'(count_reg) >= DEPTH_C);
    assign full_after = (count_next >= cap_reg) || (CMP_W'(count_next) >= DEPTH_C);
    assign clamp_end  = (in_end < count_reg) ? in_end : count_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_step  = (steps_reg == count_reg - 9'd1);

    // cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [BYTE_W-1:0] lo_main, up_main, lo_aux;
        if (i == 0) begin : g_first
            assign lo_main = '0;
            assign lo_aux  = main_w[0];
        end else begin : g_mid
            assign lo_main = main_w[i-1];
            assign lo_aux  = aux_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_top
            assign up_main = '0;
        end else begin : g_below
            assign up_main = main_w[i+1];
        end
        bale_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .lower_main (lo_main),
            .upper_main (up_main),
            .lower_aux  (lo_aux),
            .head_main  (head),
            .main_q     (main_w[i]),
            .aux_q      (aux_w[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        steps_next    = steps_reg;
        ok_next       = ok_reg;
        rd_next       = rd_reg;
        found_next    = found_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = (state_reg == ST_IDLE);
        ctrl.op       = CELL_HOLD;
        ctrl.pos      = pos_reg;
        ctrl.last     = count_reg - 9'd1;
        ctrl.count    = count_reg;
        ctrl.value    = val_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = in_req;
                    pos_next   = in_pos;
                    val_next   = in_val;
                    steps_next = '0;
                    ok_next    = 1'b0;
                    rd_next    = '0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_DONE;
                    ctrl.pos   = in_pos;
                    ctrl.value = in_val;
                    case (in_req)
                        REQ_APPEND: begin
                            if (!full_now) begin
                                ctrl.op    = CELL_LOAD;
                                ctrl.pos   = count_reg;
                                count_next = count_reg + 9'd1;
                                ok_next    = 1'b1;
                            end
                        end
                        REQ_INSERT: begin
                            if (!full_now && in_pos <= count_reg) begin
                                ctrl.op    = CELL_SHIFT_UP;
                                count_next = count_reg + 9'd1;
                                ok_next    = 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (in_pos < count_reg) begin
                                ctrl.op    = CELL_SHIFT_DOWN;
                                count_next = count_reg - 9'd1;
                                ok_next    = 1'b1;
                            end
                        end
                        REQ_DEL_RANGE: begin
                            if (in_pos <= in_end) begin
                                ok_next = 1'b1;
                                if (in_pos < clamp_end) begin
                                    steps_next = clamp_end - in_pos;
                                    state_next = ST_DEL;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            ctrl.op    = CELL_ZERO;
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        REQ_READ: begin
                            if (in_pos < count_reg) begin
                                ok_next    = 1'b1;
                                state_next = ST_ROT;
                            end
                        end
                        REQ_FIND: begin
                            if (count_reg != '0) state_next = ST_ROT;
                        end
                        REQ_REVERSE: begin
                            ok_next = 1'b1;
                            if (count_reg > 9'd1) state_next = ST_POP;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DEL: begin
                ctrl.op    = CELL_SHIFT_DOWN;
                count_next = count_reg - 9'd1;
                steps_next = steps_reg - 9'd1;
                if (steps_reg == 9'd1) state_next = ST_DONE;
            end
            ST_ROT: begin
                ctrl.op = CELL_ROTATE;
                if (req_reg == REQ_READ && steps_reg == pos_reg) rd_next = head;
                if (req_reg == REQ_FIND && !found_reg && head == val_reg) begin
                    found_next = 1'b1;
                    ok_next    = 1'b1;
                    idx_next   = steps_reg[BYTE_W-1:0];
                end
                steps_next = steps_reg + 9'd1;
                if (last_step) state_next = ST_DONE;
            end
            ST_POP: begin
                ctrl.op    = CELL_POP;
                steps_next = steps_reg + 9'd1;
                if (last_step) state_next = ST_COPY;
            end
            ST_COPY: begin
                ctrl.op    = CELL_COPY;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, full_after, (count_reg == '0), count_reg,
                                     idx_reg, found_reg, rd_reg, ok_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cap_reg      <= 9'd256;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        steps_reg   <= steps_next;
        ok_reg      <= ok_next;
        rd_reg      <= rd_next;
        found_reg   <= found_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= DEPTH_C)
        else $error("entry count beyond store depth");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented outside done state");

    a_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE || state_reg == ST_COPY || state_reg == ST_POP)
        |=> count_reg == $past(count_reg))
        else $error("count changed while no request was modifying it");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[27] == (m_tdata_reg[26:18] == 9'd0)))
        else $error("empty flag disagrees with item count");

endmodule
